### hdl/error_diffusion_palette_dither_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the error diffusion palette dither block
// Shared property wrappers, clocked on the rising edge, off during reset.
// ---------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_PALETTE_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_PALETTE_DITHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDPD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edpd: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define EDPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edpd: next-cycle property failed");

`endif

### hdl/edpd_pkg.sv
// ---------------------------------------------------------------------------
// Error diffusion palette dither package
// Types, codes and helper functions of the dither block.
// ---------------------------------------------------------------------------
package edpd_pkg;

  // Channel and error widths.
  localparam int COLOR_W = 8;
  localparam int ERR_W   = 13;
  localparam int DIST_W  = 18;

  // Register indexes of the configuration port.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DITHER_AMOUNT = 2'd0;
  localparam cfg_idx_t CFG_PALETTE_SIZE  = 2'd1;
  localparam cfg_idx_t CFG_LINE_WIDTH    = 2'd2;

  // Item kinds carried in tuser.
  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  // Register reset values and limits.
  localparam logic [9:0]  DITHER_RESET = 10'd128;
  localparam logic [9:0]  DITHER_MAX   = 10'd512;
  localparam logic [4:0]  PSIZE_RESET  = 5'd16;
  localparam logic [11:0] WIDTH_RESET  = 12'd2048;

  // One error value per channel, in 1/16 units.
  typedef logic signed [ERR_W-1:0] err_t;
  // Red in the lowest lane, then green, then blue.
  typedef logic [2:0][ERR_W-1:0]   err_vec_t;
  typedef logic [2:0][COLOR_W-1:0] rgb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_ADJ,
    ST_SRCH,
    ST_DONE,
    ST_FLUSH1,
    ST_FLUSH2
  } state_e;

  // Saturate a 14-bit sum to the 13-bit error range.
  function automatic err_t sat13(logic signed [ERR_W:0] v);
    err_t r;
    if (v > 14'sd4095) begin
      r = 13'sd4095;
    end else if (v < -14'sd4096) begin
      r = -13'sd4096;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/error_diffusion_palette_dither.sv
// ---------------------------------------------------------------------------
// Error diffusion palette dither
// Floyd-Steinberg dither of a raster RGB stream onto a searched palette.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Beat contents
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o pixel or palette write
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i chosen palette color
// cfg       in         cfg_valid_i/cfg_ready_o         register index, data
//
// A palette write is taken only in the idle state. A pixel steps through the
// read, adjust, search and done states; the palette search reads one entry a
// cycle from the palette memory. The last pixel of a row then passes through
// the flush states, which write the pending next-row errors and swap the error
// banks. No clearing pass follows reset: a fill count marks how much of the read bank holds valid errors.
// A stalled output holds its beat while the next item is taken; a pixel that
// finishes while that beat still waits stays in its last state until it leaves.

module error_diffusion_palette_dither #(
  parameter int PALETTE_DEPTH = 16,
  parameter int MAX_WIDTH     = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: red[7:0], green[15:8], blue[23:16], entry_index[27:24], zero pad.
  input  logic [31:0] s_axis_tdata_i,
  // tuser: func[0], start_frame[1].
  input  logic [1:0]  s_axis_tuser_i,
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16], out_index[27:24].
  output logic [31:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  localparam int STORE_DEPTH = MAX_WIDTH + 2;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_WIDTH);
  localparam int CMP_W       = (CNT_W + 1 > 12) ? CNT_W + 1 : 12;
  localparam int PAL_AW      = $clog2(PALETTE_DEPTH);
  localparam int PCNT_W      = $clog2(PALETTE_DEPTH + 1);
  localparam int PCMP_W      = (PCNT_W > 5) ? PCNT_W : 5;

  // Configuration registers.
  logic [9:0]  dither_q;
  logic [4:0]  psize_q;
  logic [11:0] lwidth_q;

  // Control state.
  edpd_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]  col_q;
  logic              rbank_q;
  logic [FILL_W-1:0] read_fill_q;
  logic [PCNT_W-1:0] issue_q;
  logic              pal_vld_q;
  logic              pal_last_q;
  logic              out_valid_q;

  // Pixel datapath registers.
  edpd_pkg::rgb_t             px_q;
  logic [CNT_W-1:0]           x_q;
  logic [IDX_W-1:0]           raddr_q;
  edpd_pkg::err_vec_t         rd_a_q, rd_b_q;
  edpd_pkg::err_vec_t         err_q;
  edpd_pkg::rgb_t             adj_q;
  edpd_pkg::rgb_t             pal_rd_q;
  logic [PAL_AW-1:0]          pal_idx_q;
  logic [edpd_pkg::DIST_W-1:0] best_dist_q;
  logic [PAL_AW-1:0]          best_idx_q;
  edpd_pkg::rgb_t             best_rgb_q;
  edpd_pkg::err_vec_t         pend1_q, pend2_q, carry_q;
  logic [27:0]                out_q;

  // Memories.
  edpd_pkg::rgb_t     pal_mem [PALETTE_DEPTH];
  edpd_pkg::err_vec_t mem_a   [STORE_DEPTH];
  edpd_pkg::err_vec_t mem_b   [STORE_DEPTH];

  // Input beat fields.
  logic           in_func, in_start;
  edpd_pkg::rgb_t in_rgb;
  logic [3:0]     in_index;

  assign in_func     = s_axis_tuser_i[0];
  assign in_start    = s_axis_tuser_i[1];
  assign in_rgb      = {s_axis_tdata_i[23:16], s_axis_tdata_i[15:8], s_axis_tdata_i[7:0]};
  assign in_index    = s_axis_tdata_i[27:24];

  assign s_axis_tready_o = (state_q == edpd_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;

  logic s_acc, px_acc, pal_we;
  logic [PAL_AW-1:0] pal_waddr;
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign px_acc    = s_acc && (in_func == edpd_pkg::FUNC_PIXEL);
  assign pal_we    = s_acc && (in_func == edpd_pkg::FUNC_PALETTE)
                     && (int'(in_index) < PALETTE_DEPTH);
  assign pal_waddr = PAL_AW'(in_index);

  // Effective register values after clamping.
  logic [9:0]        amt;
  logic [PCMP_W-1:0] ps_ext, pcount_w;
  logic [PCNT_W-1:0] pcount;
  logic [CMP_W-1:0]  lw_ext, width_eff;

  always_comb begin
    amt    = (dither_q > edpd_pkg::DITHER_MAX) ? edpd_pkg::DITHER_MAX : dither_q;
    ps_ext = PCMP_W'(psize_q);
    if (ps_ext == '0) begin
      pcount_w = PCMP_W'(1);
    end else if (ps_ext > PCMP_W'(PALETTE_DEPTH)) begin
      pcount_w = PCMP_W'(PALETTE_DEPTH);
    end else begin
      pcount_w = ps_ext;
    end
    pcount = PCNT_W'(pcount_w);
    lw_ext = CMP_W'(lwidth_q);
    if (lw_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dither_q <= edpd_pkg::DITHER_RESET;
      psize_q  <= edpd_pkg::PSIZE_RESET;
      lwidth_q <= edpd_pkg::WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        edpd_pkg::CFG_DITHER_AMOUNT: dither_q <= cfg_data_i[9:0];
        edpd_pkg::CFG_PALETTE_SIZE:  psize_q  <= cfg_data_i[4:0];
        edpd_pkg::CFG_LINE_WIDTH:    lwidth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read address of the error below-current entry for an accepted pixel.
  logic [CNT_W-1:0] x_in;
  logic [IDX_W-1:0] raddr;
  assign x_in  = in_start ? '0 : col_q;
  assign raddr = IDX_W'(x_in) + IDX_W'(1);

  // Diffused error at the pixel: read bank entry, masked by the fill count,
  // plus the right-hand carry of the previous pixel.
  edpd_pkg::err_vec_t rd_sel, err_sum;
  logic               rd_in_fill;
  always_comb begin
    rd_sel     = rbank_q ? rd_b_q : rd_a_q;
    rd_in_fill = FILL_W'(raddr_q) < read_fill_q;
    for (int c = 0; c < 3; c++) begin
      err_sum[c] = edpd_pkg::sat13(
        (rd_in_fill ? {rd_sel[c][edpd_pkg::ERR_W-1], rd_sel[c]} : 14'sd0)
        + {carry_q[c][edpd_pkg::ERR_W-1], carry_q[c]});
    end
  end

  // Scaled error, truncated toward zero, added and clamped.
  logic signed [23:0] prod   [3];
  logic signed [23:0] prod_r [3];
  logic signed [12:0] v13    [3];
  edpd_pkg::rgb_t     adj_d;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]   = $signed(err_q[c]) * $signed({1'b0, amt});
      prod_r[c] = prod[c] + ((prod[c] < 0) ? 24'sd4095 : 24'sd0);
      v13[c]    = $signed({5'b0, px_q[c]})
                  + $signed({prod_r[c][23], prod_r[c][23:12]});
      if (v13[c] < 0) begin
        adj_d[c] = 8'd0;
      end else if (v13[c] > 13'sd255) begin
        adj_d[c] = 8'd255;
      end else begin
        adj_d[c] = v13[c][7:0];
      end
    end
  end

  // Squared distance of the palette entry read last cycle.
  logic signed [8:0]  dch [3];
  logic signed [17:0] sq  [3];
  logic [edpd_pkg::DIST_W-1:0] cand_dist;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dch[c] = $signed({1'b0, adj_q[c]}) - $signed({1'b0, pal_rd_q[c]});
      sq[c]  = dch[c] * dch[c];
    end
    cand_dist = edpd_pkg::DIST_W'(sq[0][15:0]) + edpd_pkg::DIST_W'(sq[1][15:0])
                + edpd_pkg::DIST_W'(sq[2][15:0]);
  end

  // Quantization error and its weighted shares.
  logic signed [8:0]  qe  [3];
  logic signed [13:0] e1  [3];
  logic signed [13:0] e3  [3];
  logic signed [13:0] e5  [3];
  logic signed [13:0] e7  [3];
  edpd_pkg::err_vec_t wr_here, pend1_d, pend2_d, carry_d;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qe[c] = $signed({1'b0, adj_q[c]}) - $signed({1'b0, best_rgb_q[c]});
      e1[c] = {{5{qe[c][8]}}, qe[c]};
      e3[c] = (e1[c] <<< 1) + e1[c];
      e5[c] = (e1[c] <<< 2) + e1[c];
      e7[c] = (e1[c] <<< 3) - e1[c];
      wr_here[c] = edpd_pkg::sat13({pend1_q[c][edpd_pkg::ERR_W-1], pend1_q[c]} + e3[c]);
      pend1_d[c] = edpd_pkg::sat13({pend2_q[c][edpd_pkg::ERR_W-1], pend2_q[c]} + e5[c]);
      pend2_d[c] = edpd_pkg::sat13(e1[c]);
      carry_d[c] = edpd_pkg::sat13(e7[c]);
    end
  end

  logic row_end, out_free;
  assign row_end  = (CMP_W'(x_q) + CMP_W'(1)) >= width_eff;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Next state and strobes.
  logic               pal_re, err_we, out_load;
  logic [IDX_W-1:0]   err_waddr;
  edpd_pkg::err_vec_t err_wdata;
  always_comb begin
    state_d   = state_q;
    pal_re    = 1'b0;
    err_we    = 1'b0;
    err_waddr = IDX_W'(x_q);
    err_wdata = wr_here;
    out_load  = 1'b0;
    case (state_q)
      edpd_pkg::ST_IDLE: begin
        if (px_acc) state_d = edpd_pkg::ST_RD;
      end
      edpd_pkg::ST_RD: begin
        state_d = edpd_pkg::ST_ADJ;
      end
      edpd_pkg::ST_ADJ: begin
        state_d = edpd_pkg::ST_SRCH;
      end
      edpd_pkg::ST_SRCH: begin
        pal_re = (issue_q < pcount);
        if (pal_vld_q && pal_last_q) state_d = edpd_pkg::ST_DONE;
      end
      edpd_pkg::ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          err_we   = 1'b1;
          state_d  = row_end ? edpd_pkg::ST_FLUSH1 : edpd_pkg::ST_IDLE;
        end
      end
      edpd_pkg::ST_FLUSH1: begin
        err_we    = 1'b1;
        err_waddr = IDX_W'(x_q) + IDX_W'(1);
        err_wdata = pend1_q;
        state_d   = edpd_pkg::ST_FLUSH2;
      end
      edpd_pkg::ST_FLUSH2: begin
        err_we    = 1'b1;
        err_waddr = IDX_W'(x_q) + IDX_W'(2);
        err_wdata = pend2_q;
        state_d   = edpd_pkg::ST_IDLE;
      end
      default: state_d = edpd_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= edpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Palette memory.
  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[pal_waddr] <= in_rgb;
    if (pal_re) pal_rd_q <= pal_mem[issue_q[PAL_AW-1:0]];
  end

  // Error bank A; it is the write bank while bank B is read.
  always_ff @(posedge clk_i) begin
    if (err_we && rbank_q) mem_a[err_waddr] <= err_wdata;
    if (px_acc) rd_a_q <= mem_a[raddr];
  end

  // Error bank B.
  always_ff @(posedge clk_i) begin
    if (err_we && !rbank_q) mem_b[err_waddr] <= err_wdata;
    if (px_acc) rd_b_q <= mem_b[raddr];
  end

  // Row and search control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      rbank_q     <= 1'b0;
      read_fill_q <= '0;
      issue_q     <= '0;
      pal_vld_q   <= 1'b0;
      pal_last_q  <= 1'b0;
      pend1_q     <= '0;
      pend2_q     <= '0;
      carry_q     <= '0;
    end else begin
      pal_vld_q  <= pal_re;
      pal_last_q <= pal_re && (issue_q == pcount - PCNT_W'(1));
      if (pal_re) issue_q <= issue_q + PCNT_W'(1);
      if (state_q == edpd_pkg::ST_ADJ) issue_q <= '0;
      // A frame start empties the read bank, by its fill count, and the pending errors.
      if (px_acc && in_start) begin
        read_fill_q <= '0;
        pend1_q     <= '0;
        pend2_q     <= '0;
        carry_q     <= '0;
      end
      if (state_q == edpd_pkg::ST_DONE && out_free) begin
        pend1_q <= pend1_d;
        pend2_q <= pend2_d;
        carry_q <= carry_d;
        if (!row_end) col_q <= x_q + CNT_W'(1);
      end
      // Row end: the written bank becomes the read bank.
      if (state_q == edpd_pkg::ST_FLUSH2) begin
        rbank_q     <= !rbank_q;
        read_fill_q <= FILL_W'(x_q) + FILL_W'(3);
        col_q       <= '0;
        pend1_q     <= '0;
        pend2_q     <= '0;
        carry_q     <= '0;
      end
    end
  end

  // Pixel payload registers.
  always_ff @(posedge clk_i) begin
    if (px_acc) begin
      px_q    <= in_rgb;
      x_q     <= x_in;
      raddr_q <= raddr;
    end
    if (state_q == edpd_pkg::ST_RD) err_q <= err_sum;
    if (state_q == edpd_pkg::ST_ADJ) begin
      adj_q       <= adj_d;
      best_dist_q <= '1;
    end
    if (pal_re) pal_idx_q <= issue_q[PAL_AW-1:0];
    // Strict compare keeps the lowest index on ties.
    if (pal_vld_q && (cand_dist < best_dist_q)) begin
      best_dist_q <= cand_dist;
      best_idx_q  <= pal_idx_q;
      best_rgb_q  <= pal_rd_q;
    end
    if (out_load) out_q <= {4'(best_idx_q), best_rgb_q[2], best_rgb_q[1], best_rgb_q[0]};
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q};

  // Checks.
`include "error_diffusion_palette_dither_defines.svh"
  `EDPD_ASSERT_IMPLIES(a_fill_bound, clk_i, rst_ni, 1'b1, read_fill_q <= FILL_W'(STORE_DEPTH))
  `EDPD_ASSERT_IMPLIES(a_waddr_bound, clk_i, rst_ni, err_we, int'(err_waddr) < STORE_DEPTH)
  `EDPD_ASSERT_NEXT(a_pixel_reads, clk_i, rst_ni, px_acc, state_q == edpd_pkg::ST_RD)
  `EDPD_ASSERT_NEXT(a_search_ends, clk_i, rst_ni, pal_vld_q && pal_last_q, state_q == edpd_pkg::ST_DONE)

endmodule
